>>> src/adjacent_diff_array_count_dp_defines.svh
// Assertion macros shared by the adjacent-difference array counter.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef ADJACENT_DIFF_ARRAY_COUNT_DP_DEFINES_SVH
`define ADJACENT_DIFF_ARRAY_COUNT_DP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ADC_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ADC_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define ADC_ASSERT_IMP(lbl, pre, post, msg)
`define ADC_ASSERT_NXT(lbl, pre, post, msg)

`endif

`endif

>>> src/adc_dp_pkg.sv
// Shared types, constants and modular helpers for the adjacent-difference counter.
// No dependencies; used by the top level.
package adc_dp_pkg;

    localparam int COUNT_W = 30;
    localparam int SUM_W   = 32;

    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [SUM_W-1:0]   t_sum;

    localparam t_count COUNT_MOD = 30'd1000000007;
    localparam t_sum   MOD_X1    = 32'd1000000007;
    localparam t_sum   MOD_X2    = 32'd2000000014;

    localparam logic [7:0] MAX_VALUE_RESET = 8'd100;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_HOLD
    } t_state;

    // Reduce a sum of three residues (below three times the modulus).
    function automatic t_count reduce3(input t_sum s);
        t_sum r;
        if (s >= MOD_X2) begin
            r = s - MOD_X2;
        end else if (s >= MOD_X1) begin
            r = s - MOD_X1;
        end else begin
            r = s;
        end
        return r[COUNT_W-1:0];
    endfunction

    // Modular add of two residues.
    function automatic t_count mod_add(input t_count a, input t_count b);
        logic [COUNT_W:0] s;
        logic [COUNT_W:0] r;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, COUNT_MOD}) begin
            r = s - {1'b0, COUNT_MOD};
        end else begin
            r = s;
        end
        return r[COUNT_W-1:0];
    endfunction

endpackage

>>> src/adc_dp_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No package dependencies.
module adc_dp_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/adjacent_diff_array_count_dp.sv
// Top level of the adjacent-difference array counter: control, sweep datapath, stream ports.
// Depends on adc_dp_pkg, adc_dp_ram and adjacent_diff_array_count_dp_defines.svh.
//
// This block counts arrays whose values lie in 1..max_value and whose neighboring
// elements differ by at most one, modulo 1000000007. Array elements arrive one per
// item on the slave stream: tdata carries the element value (0 means the position is
// free, anything else fixes it) and tlast marks the final element. The count row, one
// 30-bit entry per value, lives in a single-port-read, single-port-write RAM. Each
// item sweeps the whole row of MAX_VALUES entries in place: the read runs ahead of
// the write by four entries, and a two-entry window of old values plus the entry just
// read supply the three neighbors of each new value. The block takes a new item only
// once the sweep of the last one is done. On the item marked last, the modular sum of
// the new row, accumulated during the sweep, appears on the master stream; that result
// register lets the next item be taken while the result is still waiting. Values above
// max_value give a count of zero, and max_value is limited to MAX_VALUES. The row needs
// no clearing after reset: the first element of an array overwrites every entry
// without reading it. Write max_value only while the block is idle.
`include "adjacent_diff_array_count_dp_defines.svh"

module adjacent_diff_array_count_dp #(
    parameter int MAX_VALUES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Configuration: max_value.
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,

    // Element stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] element_value
    input  logic        s_axis_tlast,   // is_last

    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [29:0] array_count, [31:30] zero
);

    localparam int IDX_W = $clog2(MAX_VALUES);
    localparam int CNT_W = $clog2(MAX_VALUES + 4);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    // Sweep step at which the final write and accumulate happen.
    localparam logic [CNT_W-1:0] LAST_K = CNT_W'(MAX_VALUES + 3);

    // Control state.
    adc_dp_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]   r_k;
    logic               r_first;
    logic [7:0]         r_max_value;
    logic               r_out_vld;
    logic               r_sum_vld;
    logic               r_wr_vld;

    // Item and datapath payload.
    logic [7:0]         r_val;
    logic               r_last;
    logic               r_item_first;
    adc_dp_pkg::t_count r_win0;
    adc_dp_pkg::t_count r_win1;
    adc_dp_pkg::t_sum   r_sum;
    logic [IDX_W-1:0]   r_sum_idx;
    adc_dp_pkg::t_count r_wr_data;
    logic [IDX_W-1:0]   r_wr_idx;
    adc_dp_pkg::t_count r_acc;
    adc_dp_pkg::t_count r_out_data;

    logic               accept;
    logic               sweep_end;
    logic               out_free;
    logic               out_load;
    logic               out_from_hold;

    logic [CMP_W-1:0]   m_lim;
    logic [CMP_W-1:0]   k_ext;
    logic [CMP_W-1:0]   v_ext;
    logic               rd_en;
    logic               shift_en;
    logic               stage_b;
    logic               rd_in_row;
    logic               in_row;
    logic               match;
    logic               include_j;
    adc_dp_pkg::t_count ram_rdata;
    adc_dp_pkg::t_count nb_next;
    adc_dp_pkg::t_sum   raw_sum;
    logic [CNT_W-1:0]   j_k;
    adc_dp_pkg::t_count n_acc;

    //------------------------------------------------------------------
    // Row storage.
    //------------------------------------------------------------------
    adc_dp_ram #(
        .WIDTH (adc_dp_pkg::COUNT_W),
        .DEPTH (MAX_VALUES)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (r_wr_vld),
        .i_waddr (r_wr_idx),
        .i_wdata (r_wr_data),
        .i_re    (rd_en),
        .i_raddr (r_k[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    //------------------------------------------------------------------
    // Sweep datapath.
    //------------------------------------------------------------------
    // Effective m, limited to the row length.
    always_comb begin
        if (CMP_W'(r_max_value) > CMP_W'(MAX_VALUES)) begin
            m_lim = CMP_W'(MAX_VALUES);
        end else begin
            m_lim = CMP_W'(r_max_value);
        end
    end

    assign k_ext = CMP_W'(r_k);
    assign v_ext = CMP_W'(r_val);

    // Step k reads entry k; the RAM returns entry k-1 at step k.
    assign rd_en    = (r_state == adc_dp_pkg::ST_SWEEP) && (k_ext < CMP_W'(MAX_VALUES));
    assign shift_en = (r_state == adc_dp_pkg::ST_SWEEP) && (r_k != '0);
    // New entry j = k-2 is formed at steps 2 .. MAX_VALUES+1.
    assign stage_b  = (r_state == adc_dp_pkg::ST_SWEEP) && (k_ext >= CMP_W'(2))
                      && (k_ext <= CMP_W'(MAX_VALUES + 1));

    // Entries at or above m do not count as neighbors.
    assign rd_in_row = (k_ext < m_lim + CMP_W'(1));
    assign nb_next   = rd_in_row ? ram_rdata : '0;

    assign j_k       = r_k - CNT_W'(2);
    assign in_row    = (k_ext < m_lim + CMP_W'(2));
    assign match     = (v_ext == '0) || (v_ext == k_ext - CMP_W'(1));
    assign include_j = in_row && match;

    always_comb begin
        if (!include_j) begin
            raw_sum = '0;
        end else if (r_item_first) begin
            raw_sum = adc_dp_pkg::t_sum'(1);
        end else begin
            raw_sum = adc_dp_pkg::t_sum'(r_win0) + adc_dp_pkg::t_sum'(r_win1)
                      + adc_dp_pkg::t_sum'(nb_next);
        end
    end

    // Running total of the new row; every written value is already reduced.
    assign n_acc = r_wr_vld ? adc_dp_pkg::mod_add(r_acc, r_wr_data) : r_acc;

    //------------------------------------------------------------------
    // Control.
    //------------------------------------------------------------------
    assign sweep_end = (r_state == adc_dp_pkg::ST_SWEEP) && (r_k == LAST_K);
    assign out_free  = !r_out_vld || m_axis_tready;

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        out_from_hold = 1'b0;
        unique case (r_state)
            adc_dp_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = adc_dp_pkg::ST_SWEEP;
                end
            end
            adc_dp_pkg::ST_SWEEP: begin
                if (r_k == LAST_K) begin
                    if (!r_last) begin
                        n_state = adc_dp_pkg::ST_IDLE;
                    end else if (out_free) begin
                        out_load = 1'b1;
                        n_state  = adc_dp_pkg::ST_IDLE;
                    end else begin
                        n_state = adc_dp_pkg::ST_HOLD;
                    end
                end
            end
            adc_dp_pkg::ST_HOLD: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_from_hold = 1'b1;
                    n_state       = adc_dp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = adc_dp_pkg::ST_IDLE;
            end
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= adc_dp_pkg::ST_IDLE;
            r_k         <= '0;
            r_first     <= 1'b1;
            r_max_value <= adc_dp_pkg::MAX_VALUE_RESET;
            r_out_vld   <= 1'b0;
            r_sum_vld   <= 1'b0;
            r_wr_vld    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sum_vld <= stage_b;
            r_wr_vld  <= r_sum_vld;
            if (i_cfg_we) begin
                r_max_value <= i_cfg_wdata;
            end
            if (accept) begin
                r_k <= '0;
            end else if (r_state == adc_dp_pkg::ST_SWEEP) begin
                r_k <= r_k + CNT_W'(1);
            end
            if (sweep_end) begin
                r_first <= r_last;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_val        <= s_axis_tdata;
            r_last       <= s_axis_tlast;
            r_item_first <= r_first;
            r_win0       <= '0;
            r_win1       <= '0;
            r_acc        <= '0;
        end else begin
            if (shift_en) begin
                r_win0 <= r_win1;
                r_win1 <= nb_next;
            end
            r_acc <= n_acc;
        end
        if (stage_b) begin
            r_sum     <= raw_sum;
            r_sum_idx <= j_k[IDX_W-1:0];
        end
        if (r_sum_vld) begin
            r_wr_data <= adc_dp_pkg::reduce3(r_sum);
            r_wr_idx  <= r_sum_idx;
        end
        if (out_load) begin
            r_out_data <= out_from_hold ? r_acc : n_acc;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_out_data};

    //------------------------------------------------------------------
    // Checks.
    //------------------------------------------------------------------
    `ADC_ASSERT_IMP(a_rw_apart, r_wr_vld && rd_en, r_wr_idx != r_k[IDX_W-1:0],
        "row RAM read and write hit the same entry")
    `ADC_ASSERT_IMP(a_wr_reduced, r_wr_vld, r_wr_data < adc_dp_pkg::COUNT_MOD,
        "row entry not reduced")
    `ADC_ASSERT_IMP(a_out_reduced, r_out_vld, r_out_data < adc_dp_pkg::COUNT_MOD,
        "result not reduced")
    `ADC_ASSERT_IMP(a_pipe_idle, r_state == adc_dp_pkg::ST_IDLE, !r_sum_vld && !r_wr_vld,
        "sweep pipeline busy while idle")
    `ADC_ASSERT_NXT(a_first_rearm, sweep_end && r_last, r_first,
        "array end did not rearm first element")

endmodule

>>> tb/adjacent_diff_array_count_dp_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for adjacent_diff_array_count_dp: directed arrays, max_value sweeps,
// result backpressure and long random runs, checked against a count-row predictor.
// Depends on adc_dp_pkg and the RTL of adjacent_diff_array_count_dp only.
module adjacent_diff_array_count_dp_tb;

    localparam int MAX_VALUES    = 128;
    // Long enough to cover any sweep still in flight.
    localparam int SETTLE_CYCLES = MAX_VALUES + 16;
    localparam int ITEM_TARGET   = 1700;
    localparam int HOLD_CYCLES   = 3000;
    // The limit leaves a wide margin over a clean run.
    localparam int CYCLE_LIMIT   = 1500000;
    localparam int IDLE_PERCENT  = 24;
    localparam int SHOWN_ERRORS  = 10;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [7:0]  i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [7:0] element_value
    logic        s_axis_tlast  = 1'b0;  // is_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [29:0] array_count, [31:30] zero

    // Idle and hold-off controls for the two stream sides.
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit rx_hold    = 1'b0;

    // Predictor state: one count per value, indexed by the value itself.
    adc_dp_pkg::t_count count_row [1:MAX_VALUES];
    bit                 at_first_element = 1'b1;
    logic [7:0]         max_value_reg    = adc_dp_pkg::MAX_VALUE_RESET;

    // Array counts that the block still owes, oldest first.
    adc_dp_pkg::t_count expected_counts [$];
    adc_dp_pkg::t_count want_count;

    int cycle_count    = 0;
    int items_sent     = 0;
    int counts_checked = 0;
    int cfg_writes     = 0;
    int error_count    = 0;

    adjacent_diff_array_count_dp #(
        .MAX_VALUES (MAX_VALUES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d array counts still owed.",
                     cycle_count, expected_counts.size());
            $display("adjacent_diff_array_count_dp_tb: done, errors");
            $finish;
        end
    end

    function automatic void note_failure(input string msg);
        error_count++;
        if (error_count <= SHOWN_ERRORS) begin
            $display("[%0d] %s", cycle_count, msg);
        end
    endfunction

    // The register is limited to the row size, just as in the block.
    function automatic int value_limit();
        return (max_value_reg > MAX_VALUES) ? MAX_VALUES : int'(max_value_reg);
    endfunction

    // Advance the count row by one element. Entry v counts the valid prefixes that end in
    // value v; a fixed element keeps only its own entry, a free one updates them all.
    // On the last element the row total is owed as the array count.
    function automatic void advance_count_row(input logic [7:0] value, input logic is_last);
        adc_dp_pkg::t_count next_row [1:MAX_VALUES];
        int                 lim;
        longint unsigned    acc;
        lim = value_limit();
        for (int v = 1; v <= MAX_VALUES; v++) begin
            next_row[v] = '0;
        end
        if (at_first_element) begin
            // The first element seeds the row without reading it.
            for (int v = 1; v <= lim; v++) begin
                if (value == 0 || value == v) begin
                    next_row[v] = adc_dp_pkg::t_count'(1);
                end
            end
        end else begin
            for (int v = 1; v <= lim; v++) begin
                if (value != 0 && value != v) begin
                    continue;
                end
                acc = 64'(count_row[v]);
                if (v > 1) begin
                    acc += 64'(count_row[v-1]);
                end
                if (v < lim) begin
                    acc += 64'(count_row[v+1]);
                end
                next_row[v] = adc_dp_pkg::t_count'(acc % adc_dp_pkg::COUNT_MOD);
            end
        end
        count_row        = next_row;
        at_first_element = 1'b0;
        if (is_last) begin
            acc = 0;
            for (int v = 1; v <= lim; v++) begin
                acc = (acc + count_row[v]) % adc_dp_pkg::COUNT_MOD;
            end
            expected_counts = {expected_counts, adc_dp_pkg::t_count'(acc)};
            at_first_element = 1'b1;
        end
    endfunction

    // Offer one element and wait for the handshake. Always entered at a rising edge;
    // tvalid is left high after the handshake, so back-to-back items keep it asserted.
    task automatic send_item(input logic [7:0] value, input logic is_last);
        if (tx_idle_en && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= is_last;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        advance_count_row(value, is_last);
    endtask

    // The register may change only while the block is idle: every owed count has been
    // taken and any sweep for an element without a result has had time to finish.
    task automatic set_max_value(input logic [7:0] value);
        s_axis_tvalid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        max_value_reg = value;
        cfg_writes++;
    endtask

    // Random array: mostly free positions and fixed values that walk by at most one from
    // the previous fixed value, so that counts stay nonzero, with a little noise on top.
    task automatic send_random_array(input int len);
        int         lim;
        int         prev;
        int         pick;
        logic [7:0] value;
        lim  = value_limit();
        prev = (lim == 0) ? 1 : $urandom_range(lim, 1);
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(99);
            if (lim == 0 || pick >= 95) begin
                value = 8'($urandom_range(255));
            end else if (pick < 50) begin
                value = '0;
            end else if (pick < 85) begin
                prev = prev + $urandom_range(2) - 1;
                if (prev < 1) begin
                    prev = 1;
                end
                if (prev > lim) begin
                    prev = lim;
                end
                value = 8'(prev);
            end else begin
                prev  = $urandom_range(lim, 1);
                value = 8'(prev);
            end
            send_item(value, k == len - 1);
        end
    endtask

    function automatic int random_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 80) begin
            return $urandom_range(8, 1);
        end else if (pick < 95) begin
            return $urandom_range(30, 9);
        end
        return $urandom_range(60, 31);
    endfunction

    // Directed arrays at the reset value of max_value (100): single free and fixed
    // elements, values at and above the limit, steps of one and of two, and a value
    // above the limit that must zero the row for the rest of the array.
    task automatic test_directed_arrays();
        send_item(8'd0, 1'b1);
        send_item(8'd1, 1'b1);
        send_item(8'd100, 1'b1);
        send_item(8'd101, 1'b1);
        send_item(8'd255, 1'b1);
        send_item(8'd0, 1'b0);
        send_item(8'd0, 1'b1);
        send_item(8'd5, 1'b0);
        send_item(8'd6, 1'b1);
        send_item(8'd5, 1'b0);
        send_item(8'd7, 1'b1);
        send_item(8'd1, 1'b0);
        send_item(8'd0, 1'b1);
        send_item(8'd100, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd0, 1'b1);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b1);
        send_item(8'd128, 1'b0);
        send_item(8'd0, 1'b1);
    endtask

    // Eight settings of max_value, the extremes among them: zero allows nothing, one allows
    // a single value, and anything above the row size behaves as the row size.
    task automatic test_max_value_settings();
        logic [7:0] settings [8];
        settings = '{8'd128, 8'd1, 8'd0, 8'd255, 8'd129, 8'd2, 8'd127, 8'd3};
        foreach (settings[i]) begin
            set_max_value(settings[i]);
            send_item(8'd0, 1'b1);
            send_item(8'd128, 1'b0);
            send_item(8'd0, 1'b1);
            repeat (3) send_random_array($urandom_range(6, 1));
        end
    endtask

    // The limit changes in the middle of an array: shrink it, then grow it again, each
    // time with the block idle between two elements of the same array.
    task automatic test_limit_change_mid_array();
        set_max_value(8'd128);
        repeat (3) send_item(8'd0, 1'b0);
        set_max_value(8'd3);
        send_item(8'd0, 1'b0);
        send_item(8'd0, 1'b1);
        set_max_value(8'd2);
        send_item(8'd0, 1'b0);
        send_item(8'd2, 1'b0);
        set_max_value(8'd128);
        send_item(8'd3, 1'b0);
        send_item(8'd0, 1'b1);
    endtask

    // The receiver holds off for a long stretch while short arrays keep coming, so the
    // result register fills and the block has to stall its element stream.
    task automatic test_result_backpressure();
        set_max_value(8'd50);
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
            repeat (40) send_random_array($urandom_range(2, 1));
        join
    endtask

    // Bulk random arrays with max_value changed every 10 to 40 arrays. A stretch in the
    // middle runs with no idling on either side.
    task automatic test_random_arrays();
        int  pick;
        int  arrays_left;
        bit  quiet;
        arrays_left = 0;
        while (items_sent < ITEM_TARGET) begin
            if (arrays_left == 0) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    case ($urandom_range(3))
                        0: set_max_value(8'd0);
                        1: set_max_value(8'd1);
                        2: set_max_value(8'd128);
                        default: set_max_value(8'd255);
                    endcase
                end else if (pick < 18) begin
                    set_max_value(8'($urandom_range(255, 129)));
                end else begin
                    set_max_value(8'($urandom_range(128, 1)));
                end
                arrays_left = $urandom_range(40, 10);
            end
            quiet      = (items_sent >= 900 && items_sent < 1200);
            tx_idle_en = !quiet;
            rx_idle_en <= !quiet;
            send_random_array(random_length());
            arrays_left--;
        end
    endtask

    // Receiver: checks every accepted result against the oldest owed count, then decides
    // whether to take the next one. The two padding bits above the count must be zero.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                counts_checked++;
                if (expected_counts.size() == 0) begin
                    note_failure($sformatf("unexpected array count 0x%08h", m_axis_tdata));
                end else begin
                    want_count = expected_counts.pop_front();
                    if (m_axis_tdata !== {2'b00, want_count}) begin
                        note_failure($sformatf(
                            "array count mismatch: expected %0d, got %0d (tdata 0x%08h)",
                            want_count, m_axis_tdata[29:0], m_axis_tdata));
                    end
                end
            end
            m_axis_tready <= !rx_hold && (!rx_idle_en || $urandom_range(99) >= IDLE_PERCENT);
        end
    end

    initial begin
        for (int v = 1; v <= MAX_VALUES; v++) begin
            count_row[v] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_arrays();
        test_max_value_settings();
        test_limit_change_mid_array();
        test_result_backpressure();
        test_random_arrays();

        // Drain: every owed count must arrive, then a quiet spell catches stray results.
        s_axis_tvalid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d elements over %0d max_value writes; checked %0d array counts.",
                 items_sent, cfg_writes, counts_checked);
        $display("Failures: %0d (the first %0d shown above).", error_count, SHOWN_ERRORS);
        if (error_count == 0) begin
            $display("adjacent_diff_array_count_dp_tb: done, clean");
        end else begin
            $display("adjacent_diff_array_count_dp_tb: done, errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/adc_dp_pkg.sv
src/adc_dp_ram.sv
src/adjacent_diff_array_count_dp.sv
tb/adjacent_diff_array_count_dp_tb.sv
